FILE: design/hpz_pkg.sv
// Package with the shared constants and types of the periodic Hermite interpolator.
`default_nettype none
package hpz_pkg;

  localparam int MAX_LINE_DEF = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int POS_BITS     = 32;
  localparam int KW           = POS_BITS - FRAC_BITS;
  localparam int W_BITS       = FRAC_BITS + 4;
  localparam int PROD_BITS    = SAMPLE_BITS + W_BITS;
  localparam int ACC_BITS     = PROD_BITS + 2;
  localparam int LEN_BITS     = 9;
  localparam int IDX_BITS     = 8;
  localparam int MOD_STAGES   = 4;
  localparam int MOD_STEPS    = KW / MOD_STAGES;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

FILE: design/hpz_mod_step.sv
// One pipeline stage of the restoring remainder unit used for index wrap.
`default_nettype none
module hpz_mod_step
  import hpz_pkg::*;
#(
  parameter int RW    = 9,
  parameter int NW    = 9,
  parameter int STEPS = MOD_STEPS
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] n,
  input  wire logic [KW-1:0] mag_i,
  input  wire logic [RW-1:0] rem_i,
  output logic      [KW-1:0] mag_o,
  output logic      [RW-1:0] rem_o
);

  logic [KW-1:0] mag_nxt;
  logic [RW-1:0] rem_nxt;

  // Shift in one magnitude bit per step and subtract the length when it fits.
  always_comb begin
    logic [RW-1:0] r;
    logic [KW-1:0] m;
    r = rem_i;
    m = mag_i;
    for (int s = 0; s < STEPS; s++) begin
      r = {r[RW-2:0], m[KW-1]};
      m = {m[KW-2:0], 1'b0};
      if (r >= RW'(n)) begin
        r = r - RW'(n);
      end
    end
    rem_nxt = r;
    mag_nxt = m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_o <= mag_nxt;
      rem_o <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/hpz_line_mem.sv
// Sample line storage: one write port, four replicas each with one registered read port.
`default_nettype none
module hpz_line_mem
  import hpz_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int AW       = $clog2(MAX_LINE)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [SAMPLE_BITS-1:0]       wdata,
  input  wire logic                         re,
  input  wire logic [3:0][AW-1:0]           raddr,
  output logic      [3:0][SAMPLE_BITS-1:0]  rdata
);

  for (genvar g = 0; g < 4; g++) begin : g_rep
    logic [SAMPLE_BITS-1:0] mem [MAX_LINE];
    logic [SAMPLE_BITS-1:0] rd_r;

    // Every replica takes the same writes; each serves one tap.
    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (re) begin
        rd_r <= mem[raddr[g]];
      end
    end

    assign rdata[g] = rd_r;
  end

endmodule
`default_nettype wire

FILE: design/hpz_mac.sv
// Four-tap multiply, sum, round and saturate over three register stages.
`default_nettype none
module hpz_mac
  import hpz_pkg::*;
(
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic        [3:0][SAMPLE_BITS-1:0]  samp,
  input  wire logic        [3:0][W_BITS-1:0]       wt,
  output logic signed      [SAMPLE_BITS-1:0]       value
);

  localparam logic signed [ACC_BITS-1:0] RND = ACC_BITS'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] HI  = (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_BITS-1:0] LO  = -HI - 1;

  logic signed [PROD_BITS-1:0] prod_r [4];
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [ACC_BITS-1:0]  acc_nxt;
  logic signed [ACC_BITS-1:0]  shv;
  logic signed [SAMPLE_BITS-1:0] value_nxt;

  // Products of each tap sample with its doubled weight.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= PROD_BITS'($signed(samp[i])) * PROD_BITS'($signed(wt[i]));
      end
    end
  end

  // Sum of the four products.
  always_comb begin
    acc_nxt = ACC_BITS'(prod_r[0]) + ACC_BITS'(prod_r[1])
            + ACC_BITS'(prod_r[2]) + ACC_BITS'(prod_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  // Round half up, drop the doubling and the fraction, then saturate.
  always_comb begin
    shv = (acc_r + RND) >>> (FRAC_BITS + 1);
    priority if (shv > HI) begin
      value_nxt = HI[SAMPLE_BITS-1:0];
    end else if (shv < LO) begin
      value_nxt = LO[SAMPLE_BITS-1:0];
    end else begin
      value_nxt = shv[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/periodic_hermite_z_interpolator.sv
// Top level of the periodic cubic Hermite interpolator along one sample line.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// The index wrap runs through four remainder stages of four bits each.
// Reset clears all valid bits and sets the line length to 64; the sample
// line is not cleared and holds garbage until written.
`default_nettype none
module periodic_hermite_z_interpolator
  import hpz_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [LEN_BITS-1:0]  cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [7:0] sample_index, [23:8] sample_value, [55:24] position
  input  wire logic [55:0]          in_tdata,
  // [0] command, [1] skip
  input  wire logic [1:0]           in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [15:0] interp_value, [23:16] base_index
  output logic      [23:0]          out_tdata
);

  localparam int AW    = $clog2(MAX_LINE);
  localparam int NW    = $clog2(MAX_LINE + 1);
  localparam int RW    = AW + 1;
  localparam int NSTG  = 10;
  localparam logic [W_BITS-1:0] TONE = W_BITS'(1) << FRAC_BITS;

  logic                  adv;
  logic [LEN_BITS-1:0]   len_r;
  logic [NW-1:0]         n_r;
  logic [NW-1:0]         n_nxt;

  logic [NSTG-1:0]       v_r;
  cmd_t                  cmd_r  [6];
  logic                  wen_r  [6];
  logic [AW-1:0]         wadr_r [6];
  logic [SAMPLE_BITS-1:0] wval_r [6];
  logic                  neg_r  [5];

  logic [KW-1:0]         mag0_r;
  logic [FRAC_BITS-1:0]  t_r  [3];
  logic [FRAC_BITS-1:0]  t2_r [2];
  logic [FRAC_BITS-1:0]  t3_r;
  logic [3:0][W_BITS-1:0] w_r [3:6];
  logic [AW-1:0]         km_r [5:9];

  logic [KW-1:0]         mag_s [MOD_STAGES+1];
  logic [RW-1:0]         rem_s [MOD_STAGES+1];

  logic [2*FRAC_BITS-1:0] sq;
  logic [2*FRAC_BITS-1:0] cu;
  logic [KW-1:0]         kin;
  logic                  in_cmd;
  logic [3:0][W_BITS-1:0] w_nxt;
  logic [AW-1:0]         km_nxt;
  logic [3:0][AW-1:0]    raddr;
  logic [3:0][SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] value;

  assign adv       = !v_r[NSTG-1] || out_tready;
  assign in_tready = adv;
  assign in_cmd    = in_tuser[0];
  assign kin       = in_tdata[55:24+FRAC_BITS];

  // Line length register and its clamped form.
  always_comb begin
    priority if (len_r == '0) begin
      n_nxt = NW'(1);
    end else if (32'(len_r) > 32'(MAX_LINE)) begin
      n_nxt = NW'(MAX_LINE);
    end else begin
      n_nxt = NW'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      n_r   <= NW'(64);
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      n_r <= n_nxt;
    end
  end

  // Valid bits; masked queries never enter, writes leave after the memory stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r[0] <= in_tvalid && (in_cmd == CMD_WRITE || !in_tuser[1]);
      for (int i = 1; i < NSTG; i++) begin
        if (i == 6) begin
          v_r[i] <= v_r[5] && cmd_r[5] == CMD_QUERY;
        end else begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Input stage: split the position and carry the write fields.
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0]  <= cmd_t'(in_cmd);
      wen_r[0]  <= 32'(in_tdata[IDX_BITS-1:0]) < 32'(MAX_LINE);
      wadr_r[0] <= AW'(in_tdata[IDX_BITS-1:0]);
      wval_r[0] <= in_tdata[8 +: SAMPLE_BITS];
      neg_r[0]  <= kin[KW-1];
      mag0_r    <= kin[KW-1] ? (~kin + KW'(1)) : kin;
      t_r[0]    <= in_tdata[24 +: FRAC_BITS];
      for (int i = 1; i < 6; i++) begin
        cmd_r[i]  <= cmd_r[i-1];
        wen_r[i]  <= wen_r[i-1];
        wadr_r[i] <= wadr_r[i-1];
        wval_r[i] <= wval_r[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  // Remainder of the index magnitude by the line length.
  assign mag_s[0] = mag0_r;
  assign rem_s[0] = '0;

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    hpz_mod_step #(
      .RW    (RW),
      .NW    (NW),
      .STEPS (MOD_STEPS)
    ) u_step (
      .clk   (clk),
      .en    (adv),
      .n     (n_r),
      .mag_i (mag_s[g]),
      .rem_i (rem_s[g]),
      .mag_o (mag_s[g+1]),
      .rem_o (rem_s[g+1])
    );
  end

  // Powers of the fraction, one multiply per stage.
  assign sq = (2*FRAC_BITS)'(t_r[0]) * (2*FRAC_BITS)'(t_r[0]);
  assign cu = (2*FRAC_BITS)'(t2_r[0]) * (2*FRAC_BITS)'(t_r[1]);

  // Hermite weights, doubled so that the halves stay exact.
  always_comb begin
    logic signed [W_BITS-1:0] st, s2, s3, h00, h01, h10, h11;
    st  = signed'(W_BITS'(t_r[2]));
    s2  = signed'(W_BITS'(t2_r[1]));
    s3  = signed'(W_BITS'(t3_r));
    h00 = W_BITS'(2 * s3 - 3 * s2 + signed'(TONE));
    h01 = W_BITS'(3 * s2 - 2 * s3);
    h10 = W_BITS'(st - 2 * s2 + s3);
    h11 = s3 - s2;
    w_nxt[0] = -h10;
    w_nxt[1] = W_BITS'(2 * h00 - h11);
    w_nxt[2] = W_BITS'(2 * h01 + h10);
    w_nxt[3] = h11;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[1]  <= t_r[0];
      t_r[2]  <= t_r[1];
      t2_r[0] <= sq[2*FRAC_BITS-1:FRAC_BITS];
      t2_r[1] <= t2_r[0];
      t3_r    <= cu[2*FRAC_BITS-1:FRAC_BITS];
      w_r[3]  <= w_nxt;
      for (int i = 4; i < 7; i++) begin
        w_r[i] <= w_r[i-1];
      end
    end
  end

  // Wrapped floor index from the remainder and the sign.
  always_comb begin
    logic [RW-1:0] r;
    r = rem_s[MOD_STAGES];
    if (neg_r[4] && r != '0) begin
      km_nxt = AW'(RW'(n_r) - r);
    end else begin
      km_nxt = AW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      km_r[5] <= km_nxt;
      for (int i = 6; i < 10; i++) begin
        km_r[i] <= km_r[i-1];
      end
    end
  end

  // Tap addresses around the wrapped index.
  always_comb begin
    logic [RW-1:0] k, n, p1, p2;
    k  = RW'(km_r[5]);
    n  = RW'(n_r);
    p1 = k + RW'(1);
    p2 = k + RW'(2);
    raddr[0] = (k == '0) ? AW'(n - RW'(1)) : AW'(k - RW'(1));
    raddr[1] = AW'(k);
    raddr[2] = (p1 >= n) ? AW'(p1 - n) : AW'(p1);
    priority if (n == RW'(1)) begin
      raddr[3] = '0;
    end else if (p2 >= n) begin
      raddr[3] = AW'(p2 - n);
    end else begin
      raddr[3] = AW'(p2);
    end
  end

  hpz_line_mem #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW)
  ) u_mem (
    .clk   (clk),
    .we    (adv && v_r[5] && cmd_r[5] == CMD_WRITE && wen_r[5]),
    .waddr (wadr_r[5]),
    .wdata (wval_r[5]),
    .re    (adv),
    .raddr (raddr),
    .rdata (rdata)
  );

  hpz_mac u_mac (
    .clk   (clk),
    .en    (adv),
    .samp  (rdata),
    .wt    (w_r[6]),
    .value (value)
  );

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {IDX_BITS'(km_r[9]), value};

endmodule
`default_nettype wire

FILE: tb/periodic_hermite_z_interpolator_test.sv
// Self-checking testbench for the periodic cubic Hermite interpolator.
`timescale 1ns / 1ps
module periodic_hermite_z_interpolator_test
  import hpz_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 14;
  localparam int PHASE_BEATS = 147;

  typedef struct {
    logic [15:0] value;
    logic [7:0]  index;
  } interp_t;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  idx;
    logic [15:0] val;
    logic [31:0] pos;
    logic        skip;
    logic        typed;
    logic [15:0] want_value;
    logic [7:0]  want_index;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [LEN_BITS-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [55:0]         in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [23:0]         out_tdata;

  // Shadow copy of the line and its length, kept in step with the block.
  logic signed [15:0]  line_copy [256];
  logic [LEN_BITS-1:0] line_len;
  interp_t             pending_interp [$];
  bit                  failed = 1'b0;
  bit                  calm = 1'b0;
  int                  cycles = 0;
  int                  stall_left = 0;
  beat_t               directed [16];

  periodic_hermite_z_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Hermite interpolation over the shadow line at a Q16.16 position.
  function automatic interp_t hermite_at(logic [31:0] pos);
    longint  t, t2, t3, h00, h01, h10, h11, k, n, km, acc, v;
    longint  w [4];
    interp_t r;
    t   = longint'(pos[15:0]);
    t2  = (t * t) >>> 16;
    t3  = (t2 * t) >>> 16;
    h00 = 2 * t3 - 3 * t2 + 65536;
    h01 = 3 * t2 - 2 * t3;
    h10 = t - 2 * t2 + t3;
    h11 = t3 - t2;
    w[0] = -h10;
    w[1] = 2 * h00 - h11;
    w[2] = 2 * h01 + h10;
    w[3] = h11;
    k = longint'($signed(pos)) >>> 16;
    n = longint'(line_len);
    if (n < 1) n = 1;
    if (n > 256) n = 256;
    km = k % n;
    if (km < 0) km += n;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      longint p;
      p = (km + i - 1) % n;
      if (p < 0) p += n;
      acc += longint'(line_copy[p]) * w[i];
    end
    v = (acc + 65536) >>> 17;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.value = v[15:0];
    r.index = km[7:0];
    return r;
  endfunction

  // Present one beat, wait for the handshake, then update the shadow state.
  task automatic send_beat(beat_t b);
    interp_t e;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.pos, b.val, b.idx};
    in_tuser  <= {b.skip, b.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (b.cmd == CMD_WRITE) begin
      line_copy[b.idx] = b.val;
    end else if (!b.skip) begin
      if (b.typed) begin
        e.value = b.want_value;
        e.index = b.want_index;
      end else begin
        e = hermite_at(b.pos);
      end
      pending_interp = {pending_interp, e};
    end
  endtask

  // Let every result come out before the line length is changed.
  task automatic drain_and_set_len(logic [LEN_BITS-1:0] len);
    in_tvalid <= 1'b0;
    while (pending_interp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_len = len;
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    b.typed = 1'b0;
    b.want_value = '0;
    b.want_index = '0;
    b.idx  = 8'($urandom);
    b.val  = 16'($urandom);
    b.skip = ($urandom_range(0, 9) == 0);
    b.cmd  = ($urandom_range(0, 9) < 3) ? CMD_WRITE : CMD_QUERY;
    if ($urandom_range(0, 2) == 0) begin
      b.pos = $urandom;
    end else begin
      b.pos[31:16] = 16'($signed($urandom_range(0, 1200)) - 600);
      b.pos[15:0]  = 16'($urandom);
    end
    return b;
  endfunction

  // Result checker against the oldest pending interpolation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_interp.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        failed = 1'b1;
      end else begin
        interp_t e;
        e = pending_interp.pop_front();
        if (out_tdata[15:0] !== e.value) begin
          $display("%0t: interp_value expected %h actual %h", $time, e.value,
                   out_tdata[15:0]);
          failed = 1'b1;
        end
        if (out_tdata[23:16] !== e.index) begin
          $display("%0t: base_index expected %h actual %h", $time, e.index,
                   out_tdata[23:16]);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [LEN_BITS-1:0] lens [8];
    beat_t b;
    lens = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd300, 9'd2, 9'd3, 9'd100};
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b1;
    line_len = LEN_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole line so that no query ever reads an unwritten entry.
    for (int i = 0; i < 256; i++) begin
      b = '{CMD_WRITE, 8'(i), 16'($urandom), 32'h0, 1'b0, 1'b0, 16'h0, 8'h0};
      send_beat(b);
    end

    // Directed beats at the reset length of 64; integer positions give the
    // sample itself, so the unskipped queries at 0, 5 and 64 carry a typed expectation.
    directed[0]  = '{CMD_WRITE, 8'd5,   16'h7FFF, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[1]  = '{CMD_QUERY, 8'd0,   16'h0,    32'h0005_0000, 1'b0, 1'b1, 16'h7FFF, 8'd5};
    directed[2]  = '{CMD_WRITE, 8'd0,   16'h8000, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[3]  = '{CMD_QUERY, 8'd0,   16'h0,    32'h0000_0000, 1'b0, 1'b1, 16'h8000, 8'd0};
    directed[4]  = '{CMD_QUERY, 8'd0,   16'h0,    32'h0040_0000, 1'b0, 1'b1, 16'h8000, 8'd0};
    directed[5]  = '{CMD_QUERY, 8'd0,   16'h0,    32'h0005_0000, 1'b1, 1'b0, 16'h0, 8'h0};
    directed[6]  = '{CMD_WRITE, 8'd255, 16'h1234, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0, 8'h0};
    directed[7]  = '{CMD_WRITE, 8'd10,  16'h8000, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[8]  = '{CMD_WRITE, 8'd11,  16'h7FFF, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[9]  = '{CMD_WRITE, 8'd12,  16'h7FFF, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[10] = '{CMD_WRITE, 8'd13,  16'h8000, 32'h0,        1'b0, 1'b0, 16'h0, 8'h0};
    directed[11] = '{CMD_QUERY, 8'd0,   16'h0,    32'h000B_8000, 1'b0, 1'b0, 16'h0, 8'h0};
    directed[12] = '{CMD_QUERY, 8'd0,   16'h0,    32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0, 8'h0};
    directed[13] = '{CMD_QUERY, 8'd0,   16'h0,    32'h8000_0000, 1'b0, 1'b0, 16'h0, 8'h0};
    directed[14] = '{CMD_QUERY, 8'd0,   16'h0,    32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0, 8'h0};
    directed[15] = '{CMD_QUERY, 8'd0,   16'h0,    32'h0000_FFFF, 1'b0, 1'b0, 16'h0, 8'h0};
    foreach (directed[i]) send_beat(directed[i]);

    // Random phases, one line length each; the last phase runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      drain_and_set_len(lens[ph]);
      calm = (ph == 7);
      for (int i = 0; i < PHASE_BEATS; i++) send_beat(random_beat());
    end

    in_tvalid <= 1'b0;
    while (pending_interp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
